### rtl/lcm_pkg.sv
// lcm_pkg: shared widths, beat types and datapath structs of the lcm unit
// no dependencies; imported by lcm_alu, lcm_core and lcm_unit_top
`default_nettype none

package lcm_pkg;

	// fixed width of the operand and result fields on the ports
	localparam int FIELD_W = 64;

	// working width of the datapath, 8 to 64
	localparam int DATA_WIDTH = 64;

	// bits of the gcd shift count and of the step counter
	localparam int CNT_W = $clog2(DATA_WIDTH);

	// input beat
	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
	} lcm_in_t;

	// result beat
	typedef struct packed {
		logic [FIELD_W-1:0] lcm_value;
		logic               div_zero;
	} lcm_out_t;

	// request to the shared add/subtract unit
	typedef struct packed {
		logic [DATA_WIDTH-1:0] op_a;
		logic [DATA_WIDTH-1:0] op_b;
		logic                  sub;
	} alu_req_t;

	// answer of the shared unit; carry set on subtract means op_a >= op_b
	typedef struct packed {
		logic [DATA_WIDTH-1:0] sum;
		logic                  carry;
	} alu_rsp_t;

	// finished result from the sequencer
	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  div_zero;
	} core_res_t;

endpackage

`default_nettype wire

### rtl/lcm_alu.sv
// lcm_alu: the one shared add/subtract and compare unit of the lcm datapath
// depends on lcm_pkg
`default_nettype none

module lcm_alu (
	input  lcm_pkg::alu_req_t req,
	output lcm_pkg::alu_rsp_t rsp
);
	import lcm_pkg::*;

	logic [DATA_WIDTH-1:0] b_eff;
	logic [DATA_WIDTH:0]   total;

	// a + b, or a + ~b + 1 for a - b; carry out doubles as a >= b
	always_comb begin
		b_eff = req.sub ? ~req.op_b : req.op_b;
		total = {1'b0, req.op_a} + {1'b0, b_eff} + {{DATA_WIDTH{1'b0}}, req.sub};
		rsp.sum   = total[DATA_WIDTH-1:0];
		rsp.carry = total[DATA_WIDTH];
	end

endmodule

`default_nettype wire

### rtl/lcm_core.sv
// lcm_core: sequencer and working registers for binary gcd, restoring
// division and shift-add multiply; depends on lcm_pkg, drives lcm_alu
`default_nettype none

module lcm_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [lcm_pkg::DATA_WIDTH-1:0] ma,
	input  wire [lcm_pkg::DATA_WIDTH-1:0] mb,
	output logic                      idle,
	output logic                      res_valid,
	input  wire                       res_ready,
	output lcm_pkg::core_res_t        res,
	output lcm_pkg::alu_req_t         alu_req,
	input  lcm_pkg::alu_rsp_t         alu_rsp
);
	import lcm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GCD,
		S_SHIFT,
		S_DIV,
		S_MUL,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [DATA_WIDTH-1:0] a_q;    // gcd operand, then the gcd itself
	logic [DATA_WIDTH-1:0] b_q;    // gcd operand, then remainder, then product
	logic [DATA_WIDTH-1:0] ma_q;   // dividend, becomes quotient, then multiplicand
	logic [DATA_WIDTH-1:0] mb_q;   // multiplier, shifted right
	logic [CNT_W-1:0]      k_q;    // common power of two of the gcd
	logic [CNT_W-1:0]      cnt_q;
	logic                  dz_q;

	logic [DATA_WIDTH-1:0] rem_sh;
	logic                  cnt_last;

	assign rem_sh   = {b_q[DATA_WIDTH-2:0], ma_q[DATA_WIDTH-1]};
	assign cnt_last = (cnt_q == CNT_W'(DATA_WIDTH - 1));

	// operand select for the shared unit
	always_comb begin
		alu_req.op_a = a_q;
		alu_req.op_b = b_q;
		alu_req.sub  = 1'b1;
		unique case (state_q)
			S_DIV: begin
				alu_req.op_a = rem_sh;
				alu_req.op_b = a_q;
			end
			S_MUL: begin
				alu_req.op_a = b_q;
				alu_req.op_b = ma_q;
				alu_req.sub  = 1'b0;
			end
			default: ;
		endcase
	end

	assign idle         = (state_q == S_IDLE);
	assign res_valid    = (state_q == S_DONE);
	assign res.value    = b_q;
	assign res.div_zero = dz_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			ma_q    <= '0;
			mb_q    <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			dz_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						a_q     <= ma;
						b_q     <= mb;
						ma_q    <= ma;
						mb_q    <= mb;
						k_q     <= '0;
						dz_q    <= 1'b0;
						state_q <= S_GCD;
					end
				end
				// one binary gcd step per cycle
				S_GCD: begin
					if (a_q == '0 || b_q == '0) begin
						if (a_q == '0 && b_q == '0) begin
							b_q     <= '0;
							dz_q    <= 1'b1;
							state_q <= S_DONE;
						end else begin
							if (a_q == '0) begin
								a_q <= b_q;
							end
							state_q <= S_SHIFT;
						end
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + CNT_W'(1);
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (alu_rsp.carry) begin
						a_q <= alu_rsp.sum;
					end else begin
						// keep the larger value in a for the next subtract
						a_q <= b_q;
						b_q <= a_q;
					end
				end
				// put back the common factors of two
				S_SHIFT: begin
					if (k_q == '0) begin
						b_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						a_q <= a_q << 1;
						k_q <= k_q - CNT_W'(1);
					end
				end
				// restoring division, one quotient bit per cycle
				S_DIV: begin
					ma_q  <= {ma_q[DATA_WIDTH-2:0], alu_rsp.carry};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_last) begin
						b_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else begin
						b_q <= alu_rsp.carry ? alu_rsp.sum : rem_sh;
					end
				end
				// shift-add multiply, product kept modulo the width
				S_MUL: begin
					if (mb_q[0]) begin
						b_q <= alu_rsp.sum;
					end
					ma_q  <= ma_q << 1;
					mb_q  <= mb_q >> 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/lcm_unit_top.sv
// lcm_unit_top: handshake, operand magnitudes and output register of the lcm unit
// depends on lcm_pkg, lcm_alu and lcm_core
`default_nettype none

// Least common multiple of two signed operands. Each input beat yields one
// result beat: lcm_value is (|x| / gcd) * |y| kept to the low DATA_WIDTH bits,
// and div_zero is set (with lcm_value 0) when both operands are zero. One item
// is in work at a time; in_ready is high only while the sequencer is idle.
// The phases run one after another: a data dependent binary gcd loop (one
// step per cycle) on the single shared add/subtract unit, putting back the
// common factors of two, restoring division of |x| by the gcd, a shift-add
// multiply by |y| and the handoff of the result.
// A finished result sits in an output register so the next item can start
// while the previous result waits to be taken.
module lcm_unit_top (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  lcm_pkg::lcm_in_t  in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output lcm_pkg::lcm_out_t out_data
);
	import lcm_pkg::*;

	logic [DATA_WIDTH-1:0] x_raw;
	logic [DATA_WIDTH-1:0] y_raw;
	logic [DATA_WIDTH-1:0] x_mag;
	logic [DATA_WIDTH-1:0] y_mag;
	logic                  core_idle;
	logic                  core_start;
	logic                  res_valid;
	logic                  res_ready;
	core_res_t             core_res;
	alu_req_t              alu_req;
	alu_rsp_t              alu_rsp;
	logic                  out_valid_q;
	lcm_out_t              out_data_q;

	// unsigned magnitudes of the operands within the working width
	always_comb begin
		x_raw = in_data.x[DATA_WIDTH-1:0];
		y_raw = in_data.y[DATA_WIDTH-1:0];
		x_mag = x_raw[DATA_WIDTH-1] ? (~x_raw + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : x_raw;
		y_mag = y_raw[DATA_WIDTH-1] ? (~y_raw + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : y_raw;
	end

	assign in_ready   = core_idle;
	assign core_start = in_valid & core_idle;
	assign res_ready  = ~out_valid_q | out_ready;

	lcm_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	lcm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (core_start),
		.ma        (x_mag),
		.mb        (y_mag),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (core_res),
		.alu_req   (alu_req),
		.alu_rsp   (alu_rsp)
	);

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q.lcm_value <= FIELD_W'(core_res.value);
			out_data_q.div_zero  <= core_res.div_zero;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
